[rtl/core/pre_pkg.sv]
// ----------------------------------------------------------------------------
// printable run extractor package
// shared constants and types for the printable run extractor
// ----------------------------------------------------------------------------
package pre_pkg;

   localparam int RUN_BUF_DEPTH = 32;
   localparam int OFFSET_WIDTH  = 48;

   localparam int DATA_W   = 8;
   localparam int LEN_W    = 6;
   localparam int CNT_W    = $clog2(RUN_BUF_DEPTH + 1);
   localparam int IDX_W    = $clog2(RUN_BUF_DEPTH);
   localparam int CMP_W    = (CNT_W > LEN_W) ? CNT_W : LEN_W;
   localparam int CSR_DW   = 32;
   localparam int CSR_AW   = 3;

   localparam logic [LEN_W-1:0]  MIN_RUN_LEN_RST = LEN_W'(4);
   localparam logic [DATA_W-1:0] PRINT_LO        = 8'h20;
   localparam logic [DATA_W-1:0] PRINT_HI        = 8'h7E;

   localparam logic CSR_IDX_MIN_RUN_LEN = 1'b0;

   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_END  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SEND
   } pre_state_type;

endpackage

[rtl/core/pre_if.sv]
// ----------------------------------------------------------------------------
// printable run extractor channels
// valid/ready channels for input bytes and result transactions
// ----------------------------------------------------------------------------
interface pre_req_if;
   logic                        valid;
   logic                        ready;
   logic [pre_pkg::DATA_W-1:0]  data_byte;
   logic                        file_start;

   modport source (output valid, output data_byte, output file_start, input ready);
   modport sink   (input valid, input data_byte, input file_start, output ready);
endinterface

interface pre_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              item_kind;
   logic [pre_pkg::DATA_W-1:0]        char_byte;
   logic                              run_start;
   logic [pre_pkg::OFFSET_WIDTH-1:0]  start_offset;
   logic                              last;

   modport source (output valid, output item_kind, output char_byte, output run_start,
                   output start_offset, output last, input ready);
   modport sink   (input valid, input item_kind, input char_byte, input run_start,
                   input start_offset, input last, output ready);
endinterface

[rtl/core/printable_run_extractor.sv]
// a byte that causes no result leaves the input ready again; a single result is
// shown in the cycle after its byte is taken, and input waits until it is sent
// a run that reaches the threshold is replayed from the run buffer, a buffer
// read, then a send, for each character; a replay holds up to RUN_BUF_DEPTH
// characters, since a lowered threshold can release a full buffer
// synchronous reset clears the sequencer, counts and offsets; min_run_len is 4
// ----------------------------------------------------------------------------
// printable run extractor
// finds runs of printable ascii bytes and reports them with their start offset
// ----------------------------------------------------------------------------
module printable_run_extractor (
   input  logic                           clock,
   input  logic                           reset,
   pre_req_if.sink                        req_chan,
   pre_rsp_if.source                      rsp_chan,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [pre_pkg::CSR_AW-1:0]     csr_paddr,
   input  logic [pre_pkg::CSR_DW-1:0]     csr_pwdata,
   output logic [pre_pkg::CSR_DW-1:0]     csr_prdata,
   output logic                           csr_pready
);
   import pre_pkg::*;

   pre_state_type state_ff, state_in;

   logic [LEN_W-1:0]         min_run_len_ff;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     reported_ff, reported_in;
   logic [OFFSET_WIDTH-1:0]  offset_ff, offset_in;
   logic [OFFSET_WIDTH-1:0]  origin_ff, origin_in;
   logic [CNT_W-1:0]         idx_ff, idx_in;
   logic [CNT_W-1:0]         total_ff, total_in;
   logic                     burst_ff, burst_in;
   logic                     kind_ff, kind_in;
   logic [DATA_W-1:0]        char_ff, char_in;
   logic [DATA_W-1:0]        mem_q_ff;

   logic [DATA_W-1:0]        run_buffer [RUN_BUF_DEPTH];

   logic                     req_fire, rsp_fire, csr_wr;
   logic                     printable, cnt_full, mem_we, run_hit, is_last;
   logic [CNT_W-1:0]         cnt_base, cnt_new;
   logic                     rep_base;
   logic [OFFSET_WIDTH-1:0]  off_base;
   logic [CMP_W-1:0]         len_ext, eff_len;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_MIN_RUN_LEN) ?
                       CSR_DW'(min_run_len_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_run_len_ff <= MIN_RUN_LEN_RST;
      end else if (csr_wr && csr_paddr[2] == CSR_IDX_MIN_RUN_LEN) begin
         min_run_len_ff <= csr_pwdata[LEN_W-1:0];
      end
   end

   // threshold clamp
   always_comb begin
      len_ext = CMP_W'(min_run_len_ff);
      if (len_ext == '0) begin
         eff_len = CMP_W'(1);
      end else if (len_ext > CMP_W'(RUN_BUF_DEPTH)) begin
         eff_len = CMP_W'(RUN_BUF_DEPTH);
      end else begin
         eff_len = len_ext;
      end
   end

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign rsp_fire  = rsp_chan.valid && rsp_chan.ready;
   assign printable = req_chan.data_byte inside {[PRINT_LO:PRINT_HI]};

   assign cnt_base  = req_chan.file_start ? '0 : cnt_ff;
   assign rep_base  = req_chan.file_start ? 1'b0 : reported_ff;
   assign off_base  = req_chan.file_start ? '0 : offset_ff;
   assign cnt_full  = (cnt_base >= CNT_W'(RUN_BUF_DEPTH));
   assign cnt_new   = cnt_full ? cnt_base : cnt_base + CNT_W'(1);
   assign run_hit   = (CMP_W'(cnt_new) >= eff_len);
   assign mem_we    = req_fire && printable && !rep_base && !cnt_full;
   assign is_last   = (idx_ff + CNT_W'(1) == total_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (printable) begin
                  if (rep_base) begin
                     state_in = ST_SEND;
                  end else if (run_hit) begin
                     state_in = ST_READ;
                  end
               end else if (rep_base) begin
                  state_in = ST_SEND;
               end
            end
         end
         ST_READ: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_fire) begin
               state_in = (burst_ff && !is_last) ? ST_READ : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath updates
   always_comb begin
      cnt_in      = cnt_ff;
      reported_in = reported_ff;
      offset_in   = offset_ff;
      origin_in   = origin_ff;
      idx_in      = idx_ff;
      total_in    = total_ff;
      burst_in    = burst_ff;
      kind_in     = kind_ff;
      char_in     = char_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               offset_in = off_base + OFFSET_WIDTH'(1);
               cnt_in    = cnt_base;
               reported_in = rep_base;
               if (printable) begin
                  if (rep_base) begin
                     burst_in = 1'b0;
                     kind_in  = KIND_CHAR;
                     char_in  = req_chan.data_byte;
                  end else if (run_hit) begin
                     origin_in   = off_base - OFFSET_WIDTH'(cnt_new - CNT_W'(1));
                     total_in    = cnt_new;
                     idx_in      = '0;
                     burst_in    = 1'b1;
                     kind_in     = KIND_CHAR;
                     cnt_in      = '0;
                     reported_in = 1'b1;
                  end else begin
                     cnt_in = cnt_new;
                  end
               end else begin
                  burst_in    = 1'b0;
                  kind_in     = KIND_END;
                  char_in     = '0;
                  cnt_in      = '0;
                  reported_in = 1'b0;
               end
            end
         end
         ST_READ: begin
         end
         ST_SEND: begin
            if (rsp_fire && burst_ff && !is_last) begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         cnt_ff      <= '0;
         reported_ff <= 1'b0;
         offset_ff   <= '0;
         origin_ff   <= '0;
         idx_ff      <= '0;
         total_ff    <= '0;
         burst_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         reported_ff <= reported_in;
         offset_ff   <= offset_in;
         origin_ff   <= origin_in;
         idx_ff      <= idx_in;
         total_ff    <= total_in;
         burst_ff    <= burst_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      char_ff <= char_in;
   end

   // run buffer
   always_ff @(posedge clock) begin
      if (mem_we) begin
         run_buffer[cnt_base[IDX_W-1:0]] <= req_chan.data_byte;
      end
      mem_q_ff <= run_buffer[idx_ff[IDX_W-1:0]];
   end

   // channel outputs
   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = (state_ff == ST_SEND);
   assign rsp_chan.item_kind    = kind_ff;
   assign rsp_chan.char_byte    = burst_ff ? mem_q_ff : char_ff;
   assign rsp_chan.run_start    = burst_ff && (idx_ff == '0);
   assign rsp_chan.start_offset = origin_ff;
   assign rsp_chan.last         = !burst_ff || is_last;

endmodule

[tb/pre_checker.sv]
// ----------------------------------------------------------------------------
// printable run extractor checker
// watches the byte, result and register ports, predicts the reported strings
// and compares every result transaction field by field, in order
// ----------------------------------------------------------------------------
module pre_checker
   import pre_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   pre_req_if                   req_mon,
   pre_rsp_if                   rsp_mon,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [CSR_AW-1:0]    csr_paddr,
   input  logic [CSR_DW-1:0]    csr_pwdata,
   input  logic [CSR_DW-1:0]    csr_prdata,
   input  logic                 csr_pready,
   output int unsigned          fail_count,
   output int unsigned          pending
);

   typedef struct packed {
      logic                    item_kind;
      logic [DATA_W-1:0]       char_byte;
      logic                    run_start;
      logic [OFFSET_WIDTH-1:0] start_offset;
      logic                    last;
   } string_item_type;

   string_item_type         string_items [$];
   logic [DATA_W-1:0]       held_chars [RUN_BUF_DEPTH];
   int unsigned             held_count;
   logic [OFFSET_WIDTH-1:0] next_offset;
   logic [OFFSET_WIDTH-1:0] string_origin;
   logic                    string_open;
   logic [LEN_W-1:0]        threshold_reg;

   function automatic int unsigned active_threshold();
      int unsigned l;
      l = threshold_reg;
      if (l < 1) l = 1;
      if (l > RUN_BUF_DEPTH) l = RUN_BUF_DEPTH;
      return l;
   endfunction

   task automatic add_item(input logic kind, input logic [DATA_W-1:0] ch,
                           input logic first, input logic tail);
      string_item_type t;
      t.item_kind    = kind;
      t.char_byte    = ch;
      t.run_start    = first;
      t.start_offset = string_origin;
      t.last         = tail;
      string_items.push_back(t);
   endtask

   task automatic scan_byte(input logic [DATA_W-1:0] b, input logic new_file);
      if (new_file) begin
         held_count  = 0;
         string_open = 1'b0;
         next_offset = '0;
      end
      if (b >= PRINT_LO && b <= PRINT_HI) begin
         if (string_open) begin
            add_item(KIND_CHAR, b, 1'b0, 1'b1);
         end else begin
            if (held_count < RUN_BUF_DEPTH) begin
               held_chars[held_count] = b;
               held_count++;
            end
            if (held_count >= active_threshold()) begin
               string_origin = next_offset - OFFSET_WIDTH'(held_count - 1);
               for (int unsigned i = 0; i < held_count; i++)
                  add_item(KIND_CHAR, held_chars[i], i == 0, i + 1 == held_count);
               held_count  = 0;
               string_open = 1'b1;
            end
         end
      end else begin
         if (string_open) add_item(KIND_END, '0, 1'b0, 1'b1);
         held_count  = 0;
         string_open = 1'b0;
      end
      next_offset = next_offset + 1'b1;
   endtask

   task automatic check_field(input string field_name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", field_name, want, got);
         fail_count++;
      end
   endtask

   task automatic check_result();
      string_item_type e;
      if (string_items.size() == 0) begin
         $error("result transaction with no expected result: kind %0d char %0h",
                rsp_mon.item_kind, rsp_mon.char_byte);
         fail_count++;
      end else begin
         e = string_items.pop_front();
         check_field("item_kind", e.item_kind, rsp_mon.item_kind);
         check_field("char_byte", e.char_byte, rsp_mon.char_byte);
         check_field("run_start", e.run_start, rsp_mon.run_start);
         check_field("start_offset", e.start_offset, rsp_mon.start_offset);
         check_field("last", e.last, rsp_mon.last);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         string_items.delete();
         held_count    = 0;
         next_offset   = '0;
         string_origin = '0;
         string_open   = 1'b0;
         threshold_reg = MIN_RUN_LEN_RST;
         fail_count    = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) check_result();
         if (req_mon.valid && req_mon.ready) scan_byte(req_mon.data_byte, req_mon.file_start);
         if (csr_psel && csr_penable && csr_pready &&
             csr_paddr[CSR_AW-1:2] == CSR_IDX_MIN_RUN_LEN) begin
            if (csr_pwrite) threshold_reg = csr_pwdata[LEN_W-1:0];
            else check_field("min_run_len", CSR_DW'(threshold_reg), csr_prdata);
         end
      end
      pending = string_items.size();
   end

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// printable run extractor testbench
// directed byte streams, then random runs of printable text under a range of
// thresholds, with random stalls on both channels; a checker scores results
// ----------------------------------------------------------------------------
module tb;
   import pre_pkg::*;

   localparam int unsigned SETTLE_CYCLES = 80;
   localparam int unsigned STUCK_LIMIT   = 2000;
   localparam logic [CSR_AW-1:0] MIN_RUN_LEN_ADDR = {CSR_IDX_MIN_RUN_LEN, 2'b00};
   localparam logic [CSR_AW-1:0] UNUSED_ADDR      = {~CSR_IDX_MIN_RUN_LEN, 2'b00};

   logic clock = 1'b0;
   logic reset;

   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   int unsigned fail_count;
   int unsigned pending;
   int unsigned stuck_cycles = 0;
   int unsigned stall_left   = 0;
   logic        req_held     = 1'b0;
   logic        calm_tail    = 1'b0;

   pre_req_if req_chan ();
   pre_rsp_if rsp_chan ();

   printable_run_extractor u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   pre_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) || csr_psel)
         stuck_cycles = 0;
      else
         stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // result side back-pressure in random bursts
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!calm_tail && stall_left == 0 && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 11);
         if (stall_left != 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   function automatic int unsigned clamp_threshold(input int unsigned level);
      if (level < 1) return 1;
      if (level > RUN_BUF_DEPTH) return RUN_BUF_DEPTH;
      return level;
   endfunction

   function automatic logic [DATA_W-1:0] any_printable();
      return DATA_W'($urandom_range(PRINT_LO, PRINT_HI));
   endfunction

   function automatic logic [DATA_W-1:0] any_control();
      int unsigned r;
      r = $urandom_range(0, 160);
      if (r < PRINT_LO) return DATA_W'(r);
      return DATA_W'(r - PRINT_LO + PRINT_HI + 1);
   endfunction

   task automatic req_release();
      if (req_held) begin
         req_chan.valid <= 1'b0;
         req_held = 1'b0;
      end
   endtask

   task automatic send_byte(input logic [DATA_W-1:0] b, input logic new_file);
      req_chan.valid      <= 1'b1;
      req_chan.data_byte  <= b;
      req_chan.file_start <= new_file;
      req_held = 1'b1;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      if (!calm_tail && $urandom_range(0, 6) == 0) begin
         req_release();
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   task automatic csr_access(input logic wr, input logic [CSR_AW-1:0] addr,
                             input logic [CSR_DW-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
   endtask

   task automatic csr_release();
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic drain_idle();
      req_release();
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_threshold(input int unsigned level);
      drain_idle();
      csr_access(1'b1, MIN_RUN_LEN_ADDR, {(CSR_DW-LEN_W)'($urandom), LEN_W'(level)});
      csr_access(1'b0, MIN_RUN_LEN_ADDR, '0);
      csr_release();
   endtask

   // mostly runs around the threshold closed by a control byte, some raw noise
   task automatic random_text(input int unsigned count, input int unsigned level);
      int unsigned sent;
      int unsigned run_len;
      logic        new_file;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) < 7) begin
            run_len  = $urandom_range(1, 2 * clamp_threshold(level) + 2);
            new_file = ($urandom_range(0, 11) == 0);
            for (int unsigned i = 0; i < run_len; i++)
               send_byte(any_printable(), new_file && i == 0);
            send_byte(any_control(), $urandom_range(0, 19) == 0);
            sent += run_len + 1;
         end else begin
            send_byte(DATA_W'($urandom), $urandom_range(0, 7) == 0);
            sent++;
         end
      end
   endtask

   initial begin
      int unsigned levels [9] = '{1, 32, 0, 63, 33, 2, 9, 0, 5};
      int unsigned level;

      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.data_byte  <= '0;
      req_chan.file_start <= 1'b0;
      csr_psel            <= 1'b0;
      csr_penable         <= 1'b0;
      csr_pwrite          <= 1'b0;
      csr_paddr           <= '0;
      csr_pwdata          <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset value, then a write to an unmapped address must leave it alone
      csr_access(1'b0, MIN_RUN_LEN_ADDR, '0);
      csr_access(1'b1, UNUSED_ADDR, $urandom);
      csr_access(1'b0, MIN_RUN_LEN_ADDR, '0);
      csr_release();

      // printable bounds, control bytes and high bytes
      send_byte(8'h41, 1'b1);
      send_byte(8'h20, 1'b0);
      send_byte(8'h7E, 1'b0);
      send_byte(8'h62, 1'b0);
      send_byte(8'h63, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'h1F, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b0);
      // reported string cut off by a new file: no end transaction
      send_byte(8'h30, 1'b0);
      send_byte(8'h31, 1'b0);
      send_byte(8'h32, 1'b0);
      send_byte(8'h33, 1'b0);
      send_byte(8'h78, 1'b1);
      send_byte(8'h79, 1'b0);
      send_byte(8'h7A, 1'b0);
      send_byte(8'h0A, 1'b0);
      // short run cut by a new file on a control byte
      send_byte(8'h70, 1'b1);
      send_byte(8'h71, 1'b0);
      send_byte(8'h6B, 1'b0);
      send_byte(8'h00, 1'b1);

      // threshold lowered while a run is buffered
      set_threshold(12);
      send_byte(8'h4D, 1'b0);
      send_byte(8'h69, 1'b0);
      send_byte(8'h64, 1'b0);
      send_byte(8'h2D, 1'b0);
      send_byte(8'h72, 1'b0);
      set_threshold(3);
      send_byte(8'h75, 1'b0);
      send_byte(8'h0A, 1'b0);

      set_threshold(MIN_RUN_LEN_RST);
      random_text(40, MIN_RUN_LEN_RST);
      for (int i = 0; i < 9; i++) begin
         level = (i == 7) ? $urandom_range(0, 63) : levels[i];
         set_threshold(level);
         if (i == 8) calm_tail = 1'b1;
         random_text(clamp_threshold(level) > 16 ? 50 : 36, level);
      end

      drain_idle();
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
